[hdl/pcs_pkg.sv]
// Package for the precluster charge sorter: item types, cell entry type,
// register codes, controller states and the key compare function.
// No dependencies.
package pcs_pkg;

    localparam int MAX_PIXELS = 32;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;
    localparam int DSQ_W      = 25;
    localparam int MSQ_W      = 32;
    localparam int PROD_W     = MSQ_W + DSQ_W;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_SEED_ROW = 2'd1;
    localparam logic [1:0] REG_SEED_COL = 2'd2;

    // sort_mode codes
    localparam logic [1:0] MODE_CHARGE  = 2'd0;
    localparam logic [1:0] MODE_ABS     = 2'd1;
    localparam logic [1:0] MODE_CPD     = 2'd2;
    localparam logic [1:0] MODE_ABS_CPD = 2'd3;

    typedef struct packed {
        logic [11:0]        pixel_row;
        logic [11:0]        pixel_col;
        logic signed [15:0] pixel_charge;
        logic               last_pixel;
    } pix_item_t;

    typedef struct packed {
        logic signed [15:0] sorted_charge;
        logic               last_result;
        logic               dropped_flag;
    } res_item_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] charge;
        logic [MSQ_W-1:0]   msq;    // charge squared
        logic [DSQ_W-1:0]   dsq;    // squared distance, seed forced to 1
    } entry_t;

    // fill-ins at the ends of the cell row
    localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, charge: '0, msq: '0, dsq: '0};
    localparam entry_t ENTRY_HEAD  = '{valid: 1'b1, charge: '0, msq: '0, dsq: '0};

    typedef struct packed {
        logic load_en;
        logic shift;
        logic mul_en;
        logic cmp_en;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MUL,
        ST_CMP,
        ST_EMIT
    } state_t;

    function automatic logic [16:0] mag17(logic signed [15:0] c);
        logic [16:0] ext;
        ext = {c[15], c};
        return c[15] ? 17'(-ext) : ext;
    endfunction

    // sign rank: negative 0, zero 1, positive 2
    function automatic logic [1:0] sign_rank(logic signed [15:0] c);
        logic [1:0] r;
        if (c[15])
            r = 2'd0;
        else if (c == 16'sd0)
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

    // key(a) > key(b); pa = |a|^2 * dsq(b), pb = |b|^2 * dsq(a)
    function automatic logic key_gt(logic [1:0] mode, logic signed [15:0] ca,
                                    logic signed [15:0] cb,
                                    logic [PROD_W-1:0] pa, logic [PROD_W-1:0] pb);
        logic [1:0] ra;
        logic [1:0] rb;
        logic       r;
        ra = sign_rank(ca);
        rb = sign_rank(cb);
        case (mode)
            MODE_CHARGE: r = (ca > cb);
            MODE_ABS:    r = (mag17(ca) > mag17(cb));
            MODE_CPD:
            begin
                if (ra != rb)
                    r = (ra > rb);
                else if (ra == 2'd1)
                    r = 1'b0;
                else if (ra == 2'd2)
                    r = (pa > pb);
                else
                    r = (pa < pb);
            end
            default:     r = (pa > pb);
        endcase
        return r;
    endfunction

endpackage

[hdl/pcs_cell.sv]
// One sorter cell: holds one pixel entry, the products for the pair it
// forms with its right neighbor, and the swap decision. Uses pcs_pkg.
module pcs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pcs_pkg::cell_ctl_t  ctl,
    input  logic                pair_active,
    input  logic [1:0]          mode,
    input  pcs_pkg::entry_t     new_entry,
    input  pcs_pkg::entry_t     left_entry,
    input  logic                left_swap,
    input  pcs_pkg::entry_t     right_entry,
    output pcs_pkg::entry_t     entry,
    output logic                swap
);

    pcs_pkg::entry_t                  entry_reg, entry_next;
    logic [pcs_pkg::PROD_W-1:0]       p_right_reg, p_self_reg;

    always_comb
    begin
        swap = ctl.cmp_en & pair_active & entry_reg.valid & right_entry.valid &
               pcs_pkg::key_gt(mode, right_entry.charge, entry_reg.charge,
                               p_right_reg, p_self_reg);
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
            entry_next = right_entry;
        else if (ctl.load_en && !entry_reg.valid && left_entry.valid)
            entry_next = new_entry;
        else if (left_swap)
            entry_next = left_entry;
        else if (swap)
            entry_next = right_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            p_right_reg <= pcs_pkg::PROD_W'(right_entry.msq * entry_reg.dsq);
            p_self_reg  <= pcs_pkg::PROD_W'(entry_reg.msq * right_entry.dsq);
        end
    end

    assign entry = entry_reg;

endmodule

[hdl/precluster_charge_sorter.sv]
// Top level of the precluster charge sorter: APB registers, load stage,
// sort controller, row of pcs_cell and the result register. Uses pcs_pkg.
//
//  channel  | signals                      | payload
//  ---------+------------------------------+----------------------------
//  pixels   | in_valid, in_stall           | in_item  (pix_item_t)
//  results  | out_valid, out_stall         | out_item (res_item_t)
//  config   | psel, penable, pwrite, ...   | sort_mode, seed_row, seed_col
//
// Pixels load one per cycle while in_stall is low. The last pixel starts
// a sort of MAX_PIXELS odd-even phases, each a products step then a
// compare/swap step; then one result leaves per cycle unless stalled.
// in_stall is high from the last pixel until the final result enters the
// output register. Reset is asynchronous.
module precluster_charge_sorter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  pcs_pkg::pix_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output pcs_pkg::res_item_t           out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pcs_pkg::APB_AW-1:0]   paddr,
    input  logic [pcs_pkg::APB_DW-1:0]   pwdata,
    output logic [pcs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    logic [1:0]  mode_reg;
    logic [11:0] seed_row_reg, seed_col_reg;

    pcs_pkg::state_t                state_reg, state_next;
    logic [pcs_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [pcs_pkg::CNT_W-1:0]      phase_reg, phase_next;
    logic                           ovf_reg, ovf_next;
    logic                           out_valid_reg, out_valid_next;
    pcs_pkg::res_item_t             out_item_reg, out_item_next;

    pcs_pkg::cell_ctl_t             ctl;
    pcs_pkg::entry_t                new_entry;
    pcs_pkg::entry_t                cells [pcs_pkg::MAX_PIXELS];
    logic                           swaps [pcs_pkg::MAX_PIXELS];
    logic [pcs_pkg::MAX_PIXELS-1:0] valid_vec;

    logic in_acc, take, wr_en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pcs_pkg::MODE_CHARGE;
            seed_row_reg <= '0;
            seed_col_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                pcs_pkg::REG_MODE:     mode_reg     <= pwdata[1:0];
                pcs_pkg::REG_SEED_ROW: seed_row_reg <= pwdata[11:0];
                pcs_pkg::REG_SEED_COL: seed_col_reg <= pwdata[11:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pcs_pkg::REG_MODE:     prdata = {30'd0, mode_reg};
            pcs_pkg::REG_SEED_ROW: prdata = {20'd0, seed_row_reg};
            pcs_pkg::REG_SEED_COL: prdata = {20'd0, seed_col_reg};
            default:               prdata = '0;
        endcase
    end

    // ---------------- load stage ----------------
    logic signed [12:0] dr, dc;
    logic [25:0]        dsq_full;

    always_comb
    begin
        dr       = $signed({1'b0, in_item.pixel_row}) - $signed({1'b0, seed_row_reg});
        dc       = $signed({1'b0, in_item.pixel_col}) - $signed({1'b0, seed_col_reg});
        dsq_full = 26'(dr * dr) + 26'(dc * dc);
        new_entry.valid  = 1'b1;
        new_entry.charge = in_item.pixel_charge;
        new_entry.msq    = pcs_pkg::MSQ_W'(pcs_pkg::mag17(in_item.pixel_charge) *
                                           pcs_pkg::mag17(in_item.pixel_charge));
        // the seed pixel counts as distance 1
        new_entry.dsq    = (dsq_full == '0) ? pcs_pkg::DSQ_W'(1)
                                            : dsq_full[pcs_pkg::DSQ_W-1:0];
    end

    // ---------------- controller ----------------
    assign in_acc = in_valid & ~in_stall;
    assign take   = (state_reg == pcs_pkg::ST_EMIT) & cells[0].valid &
                    (~out_valid_reg | ~out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcs_pkg::ST_LOAD:
                if (in_acc && in_item.last_pixel)
                    state_next = pcs_pkg::ST_MUL;
            pcs_pkg::ST_MUL:
                state_next = pcs_pkg::ST_CMP;
            pcs_pkg::ST_CMP:
                if (phase_reg == pcs_pkg::CNT_W'(pcs_pkg::MAX_PIXELS - 1))
                    state_next = pcs_pkg::ST_EMIT;
                else
                    state_next = pcs_pkg::ST_MUL;
            pcs_pkg::ST_EMIT:
                if (take && !cells[1].valid)
                    state_next = pcs_pkg::ST_LOAD;
            default:
                state_next = pcs_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        ctl.load_en = 1'b0;
        ctl.shift   = 1'b0;
        ctl.mul_en  = 1'b0;
        ctl.cmp_en  = 1'b0;
        case (state_reg)
            pcs_pkg::ST_LOAD:
            begin
                in_stall    = 1'b0;
                ctl.load_en = in_valid & (count_reg < pcs_pkg::CNT_W'(pcs_pkg::MAX_PIXELS));
            end
            pcs_pkg::ST_MUL:  ctl.mul_en = 1'b1;
            pcs_pkg::ST_CMP:  ctl.cmp_en = 1'b1;
            pcs_pkg::ST_EMIT: ctl.shift  = take;
            default:          ;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_acc)
        begin
            if (count_reg < pcs_pkg::CNT_W'(pcs_pkg::MAX_PIXELS))
                count_next = count_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end
        if (state_reg == pcs_pkg::ST_CMP)
            phase_next = (phase_reg == pcs_pkg::CNT_W'(pcs_pkg::MAX_PIXELS - 1)) ? '0
                                                                           : phase_reg + 1'b1;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (take)
        begin
            out_valid_next              = 1'b1;
            out_item_next.sorted_charge = cells[0].charge;
            out_item_next.last_result   = ~cells[1].valid;
            out_item_next.dropped_flag  = ovf_reg;
            if (!cells[1].valid)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcs_pkg::ST_LOAD;
            count_reg     <= '0;
            phase_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < pcs_pkg::MAX_PIXELS; g++)
        begin : g_cell
            pcs_pkg::entry_t left_e, right_e;
            logic            left_s;
            logic            act;

            if (g == 0)
            begin : g_first
                assign left_e = pcs_pkg::ENTRY_HEAD;
                assign left_s = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cells[g-1];
                assign left_s = swaps[g-1];
            end

            if (g == pcs_pkg::MAX_PIXELS - 1)
            begin : g_last
                assign right_e = pcs_pkg::ENTRY_EMPTY;
            end
            else
            begin : g_inner
                assign right_e = cells[g+1];
            end

            // even phases pair (0,1),(2,3)..; odd phases pair (1,2),(3,4)..
            assign act = (1'(g) == phase_reg[0]);
            assign valid_vec[g] = cells[g].valid;

            pcs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .pair_active (act),
                .mode        (mode_reg),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_swap   (left_s),
                .right_entry (right_e),
                .entry       (cells[g]),
                .swap        (swaps[g])
            );
        end
    endgenerate

    // ---------------- assertions ----------------
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pcs_pkg::CNT_W'(pcs_pkg::MAX_PIXELS))
        else $error("pixel count beyond capacity");

    a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcs_pkg::ST_LOAD) |->
            ($countones(valid_vec) == 32'(count_reg)))
        else $error("held cells disagree with pixel count");

    a_emit_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcs_pkg::ST_EMIT) |-> cells[0].valid)
        else $error("emitting with an empty head cell");

    a_last_return: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !cells[1].valid) |=> (count_reg == '0) && !valid_vec[0])
        else $error("run end did not clear the cells");

endmodule

[verif/tb_top.sv]
// Testbench for precluster_charge_sorter: loads preclusters of pixels,
// predicts the sorted charge run per mode and checks every result item.
// Depends on pcs_pkg and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pcs_pkg::pix_item_t in_item;
    logic out_valid;
    logic out_stall = 1'b0;
    pcs_pkg::res_item_t out_item;
    logic psel, penable, pwrite;
    logic [pcs_pkg::APB_AW-1:0] paddr;
    logic [pcs_pkg::APB_DW-1:0] pwdata;
    logic [pcs_pkg::APB_DW-1:0] prdata;
    logic pready;

    precluster_charge_sorter dut (.*);

    // predictor state
    logic [1:0]         mode_q;
    logic [11:0]        seed_r_q, seed_c_q;
    logic signed [15:0] held_chg[pcs_pkg::MAX_PIXELS];
    logic [24:0]        held_dsq[pcs_pkg::MAX_PIXELS];
    int                 held_n;
    bit                 held_ovf;
    pcs_pkg::res_item_t sorted_q[$];

    int  errors = 0;
    int  n_sent, n_clusters;
    int  n_recv = 0;
    int  in_idle_pct, out_idle_pct;
    bit  hold_out;
    int  quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] mag_sq(logic signed [15:0] c);
        logic [63:0] m;
        m = c < 0 ? 64'(-32'(c)) : 64'(c);
        return m * m;
    endfunction

    function automatic bit ranks_above(int a, int b);
        logic [63:0] da, db, pa, pb;
        int sa, sb;
        da = held_dsq[a] == 0 ? 64'd1 : 64'(held_dsq[a]);
        db = held_dsq[b] == 0 ? 64'd1 : 64'(held_dsq[b]);
        pa = mag_sq(held_chg[a]) * db;
        pb = mag_sq(held_chg[b]) * da;
        sa = (held_chg[a] > 0) - (held_chg[a] < 0);
        sb = (held_chg[b] > 0) - (held_chg[b] < 0);
        case (mode_q)
            pcs_pkg::MODE_CHARGE: return held_chg[a] > held_chg[b];
            pcs_pkg::MODE_ABS:    return mag_sq(held_chg[a]) > mag_sq(held_chg[b]);
            pcs_pkg::MODE_CPD:
            begin
                if (sa != sb)
                    return sa > sb;
                if (sa == 0)
                    return 1'b0;
                return sa > 0 ? pa > pb : pa < pb;
            end
            default:              return pa > pb;
        endcase
    endfunction

    task automatic predict_pixel(pcs_pkg::pix_item_t p);
        int order[pcs_pkg::MAX_PIXELS];
        int k, dr, dc;
        pcs_pkg::res_item_t r;
        if (held_n < pcs_pkg::MAX_PIXELS)
        begin
            dr = int'(p.pixel_row) - int'(seed_r_q);
            dc = int'(p.pixel_col) - int'(seed_c_q);
            held_chg[held_n] = p.pixel_charge;
            held_dsq[held_n] = 25'(dr * dr + dc * dc);
            held_n++;
        end
        else
            held_ovf = 1'b1;
        if (!p.last_pixel)
            return;
        for (int i = 0; i < held_n; i++)
        begin
            k = i;
            while (k > 0 && ranks_above(i, order[k - 1]))
            begin
                order[k] = order[k - 1];
                k--;
            end
            order[k] = i;
        end
        for (int i = 0; i < held_n; i++)
        begin
            r.sorted_charge = held_chg[order[i]];
            r.last_result   = (i + 1 == held_n);
            r.dropped_flag  = held_ovf;
            sorted_q = {sorted_q, r};
        end
        held_n = 0;
        held_ovf = 1'b0;
        n_clusters++;
    endtask

    // returns at the accepting edge; in_valid is dropped by the next idle
    // cycle, drain() or reg_write()
    task automatic send_pixel(pcs_pkg::pix_item_t p);
        @(negedge clk);
        while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_pixel(p);
        n_sent++;
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pcs_pkg::REG_MODE:     mode_q   = val[1:0];
            pcs_pkg::REG_SEED_ROW: seed_r_q = val[11:0];
            default:               seed_c_q = val[11:0];
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic configure(logic [1:0] m, logic [11:0] sr, logic [11:0] sc);
        drain();
        reg_write(pcs_pkg::REG_MODE, {30'd0, m});
        reg_write(pcs_pkg::REG_SEED_ROW, {20'd0, sr});
        reg_write(pcs_pkg::REG_SEED_COL, {20'd0, sc});
    endtask

    function automatic pcs_pkg::pix_item_t mk(int r, int c, int q, bit l);
        pcs_pkg::pix_item_t p;
        p.pixel_row = 12'(r); p.pixel_col = 12'(c);
        p.pixel_charge = 16'(q); p.last_pixel = l;
        return p;
    endfunction

    task automatic send_cluster(int n, bit near_seed);
        int r, c, q;
        for (int i = 0; i < n; i++)
        begin
            r = near_seed ? (int'(seed_r_q) + $urandom_range(6) - 3) : $urandom_range(4095);
            c = near_seed ? (int'(seed_c_q) + $urandom_range(6) - 3) : $urandom_range(4095);
            case ($urandom_range(4))
                0: q = $urandom_range(7) - 3;
                1: q = $urandom_range(1) ? 32767 : -32768;
                default: q = $urandom_range(65535);
            endcase
            send_pixel(mk(r, c, q, i == n - 1));
        end
    endtask

    task automatic test_directed();
        configure(pcs_pkg::MODE_CHARGE, 12'd0, 12'd0);
        send_pixel(mk(0, 0, 32767, 0));
        send_pixel(mk(4095, 4095, -32768, 0));
        send_pixel(mk(1, 0, 0, 0));
        send_pixel(mk(0, 1, 5, 0));
        send_pixel(mk(2, 2, 5, 1));          // equal keys keep arrival order
        configure(pcs_pkg::MODE_ABS, 12'd4095, 12'd4095);
        send_pixel(mk(4095, 4095, -32768, 0));
        send_pixel(mk(0, 0, 32767, 0));
        send_pixel(mk(10, 20, -7, 0));
        send_pixel(mk(11, 21, 7, 1));
        configure(pcs_pkg::MODE_CPD, 12'd100, 12'd200);
        send_pixel(mk(100, 200, 3, 0));      // seed pixel counts as distance 1
        send_pixel(mk(101, 200, 3, 0));
        send_pixel(mk(103, 204, -10, 0));
        send_pixel(mk(100, 201, 0, 0));
        send_pixel(mk(99, 199, -2, 0));
        reg_write(pcs_pkg::REG_SEED_ROW, 32'd0);      // seed change while loading
        send_pixel(mk(0, 200, 6, 1));
        configure(pcs_pkg::MODE_ABS_CPD, 12'd50, 12'd50);
        send_pixel(mk(50, 50, -4, 0));
        send_pixel(mk(52, 50, 8, 0));
        reg_write(pcs_pkg::REG_MODE, {30'd0, pcs_pkg::MODE_CHARGE}); // mode read during the sort
        send_pixel(mk(50, 51, 1, 1));
        send_pixel(mk(7, 7, 9, 1));          // single-pixel precluster
    endtask

    task automatic test_overflow();
        configure(pcs_pkg::MODE_ABS_CPD, 12'd2048, 12'd2048);
        send_cluster(pcs_pkg::MAX_PIXELS, 1'b1);      // exactly full
        send_cluster(pcs_pkg::MAX_PIXELS + 3, 1'b1);  // last pixel dropped too
    endtask

    task automatic test_random(int items);
        int sent0;
        sent0 = n_sent;
        while (n_sent - sent0 < items)
        begin
            if ($urandom_range(5) == 0)
                configure(2'($urandom_range(3)), 12'($urandom_range(4095)),
                          12'($urandom_range(4095)));
            send_cluster($urandom_range(9) == 0 ? $urandom_range(30, 36)
                         : $urandom_range(1, 10), $urandom_range(3) != 0);
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_out = 1'b1;
        fork
            begin
                repeat (150) @(negedge clk);
                hold_out = 1'b0;
            end
            begin
                send_cluster(6, 1'b1);
                send_cluster(5, 1'b1);
            end
        join
        drain();                             // sender waits until all is out
        send_cluster(4, 1'b0);
    endtask

    // result side: stall driver and checker
    always @(negedge clk)
        out_stall <= hold_out || (out_idle_pct > 0 && $urandom_range(99) < out_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall))
                            ? 0 : quiet_cycles + 1;
            if (out_valid && !out_stall)
            begin
                n_recv++;
                if (sorted_q.size() == 0)
                begin
                    $display("%0t unexpected result: actual %p", $time, out_item);
                    errors++;
                end
                else
                begin
                    if (out_item !== sorted_q[0])
                    begin
                        $display("%0t mismatch: expected %p actual %p",
                                 $time, sorted_q[0], out_item);
                        errors++;
                    end
                    void'(sorted_q.pop_front());
                end
            end
            if (quiet_cycles > 5000)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; in_item = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_sent = 0; n_clusters = 0;
        hold_out = 1'b0; in_idle_pct = 0; out_idle_pct = 0;
        held_n = 0; held_ovf = 1'b0;
        mode_q = pcs_pkg::MODE_CHARGE; seed_r_q = '0; seed_c_q = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_overflow();
        in_idle_pct = 22; out_idle_pct = 84;
        test_random(120);
        in_idle_pct = 84; out_idle_pct = 22;
        test_random(80);
        in_idle_pct = 0; out_idle_pct = 0;
        test_random(100);
        test_backpressure();
        drain();
        repeat (100) @(negedge clk);

        $display("Sent %0d pixels in %0d preclusters, checked %0d sorted charges",
                 n_sent, n_clusters, n_recv);
        $display("over all four sort modes, seed extremes, overflow and stalls.");
        if (errors == 0 && sorted_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[files.f]
hdl/pcs_pkg.sv
hdl/pcs_cell.sv
hdl/precluster_charge_sorter.sv
verif/tb_top.sv
